[design/ppcd_pkg.sv]
// types, constants and the divider step shared by the crossing detector files
package ppcd_pkg;

  localparam int DIV_STEPS   = 16;
  localparam int LATENCY     = DIV_STEPS + 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic signed [31:0] DUMMY_ID  = -32'sd1;
  localparam logic [15:0]        FRAC_FULL = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_POL_COUNT      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOR_COUNT      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POL_ANGLE_BASE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOR_ANGLE_BASE = 4'd5;

  typedef struct packed {
    logic signed [31:0] marker_id;
    logic [31:0]        start_time;
    logic [31:0]        end_time;
    logic signed [31:0] start_toroidal;
    logic signed [31:0] end_toroidal;
    logic signed [31:0] start_poloidal;
    logic signed [31:0] end_poloidal;
  } in_item_t;

  typedef struct packed {
    logic        poloidal_hit;
    logic [1:0]  poloidal_index;
    logic [15:0] poloidal_fraction;
    logic        toroidal_hit;
    logic [1:0]  toroidal_index;
    logic [15:0] toroidal_fraction;
  } out_item_t;

  // classified crossing of one angle, waiting for its fraction
  typedef struct packed {
    logic        hit;
    logic [1:0]  idx;
    logic [16:0] gap;
    logic [31:0] span;
  } axis_job_t;

  typedef struct packed {
    axis_job_t pol;
    axis_job_t tor;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // one lane of the fraction divider between two stages
  typedef struct packed {
    logic        hit;
    logic [1:0]  idx;
    logic        sat;
    logic [31:0] span;
    logic [31:0] rem;
    logic [15:0] low;
    logic [15:0] quo;
  } lane_t;

  // one restoring division step: brings in the next dividend bit
  function automatic lane_t div_step(input lane_t cur);
    lane_t       nxt;
    logic [32:0] trial;
    logic [32:0] diff;
    nxt   = cur;
    trial = {cur.rem, cur.low[15]};
    diff  = trial - {1'b0, cur.span};
    nxt.low = {cur.low[14:0], 1'b0};
    if (!diff[32]) begin
      nxt.rem = diff[31:0];
      nxt.quo = {cur.quo[14:0], 1'b1};
    end else begin
      nxt.rem = trial[31:0];
      nxt.quo = {cur.quo[14:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

[design/ppcd_front.sv]
// front end: takes marker steps and finds the first crossed plane of each angle
module ppcd_front import ppcd_pkg::*; #(
  parameter int MAX_PLANES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  in_item_t    item,
  input  logic [1:0]  pol_count,
  input  logic [1:0]  tor_count,
  input  logic [15:0] pol_angle [MAX_PLANES],
  input  logic [15:0] tor_angle [MAX_PLANES],
  output logic        ready,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_taken
);

  logic front_v_r;
  job_t job_r;
  job_t job_nxt;
  logic live;

  function automatic axis_job_t scan_axis(
    input logic [1:0]         count,
    input logic [15:0]        angle [MAX_PLANES],
    input logic signed [31:0] st,
    input logic signed [31:0] en
  );
    axis_job_t   r;
    logic        up;
    logic [32:0] diff;
    logic [32:0] s;
    logic [32:0] e;
    r    = '0;
    up   = en > st;
    diff = up ? ({en[31], en} - {st[31], st}) : ({st[31], st} - {en[31], en});
    r.span = diff[31:0];
    // walk down so the lowest crossed plane wins
    for (int k = MAX_PLANES - 1; k >= 0; k--) begin
      s = {st[31], st} + {17'd0, angle[k]};
      e = {en[31], en} + {17'd0, angle[k]};
      if ((2'(k) < count) && (s[32:16] != e[32:16])) begin
        r.hit = 1'b1;
        r.idx = 2'(k);
        r.gap = up ? (17'h10000 - {1'b0, s[15:0]}) : {1'b0, s[15:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    live    = (item.marker_id != DUMMY_ID) && (item.start_time != item.end_time);
    job_nxt.pol = scan_axis(pol_count, pol_angle, item.start_toroidal, item.end_toroidal);
    job_nxt.tor = scan_axis(tor_count, tor_angle, item.start_poloidal, item.end_poloidal);
    job_nxt.pol.hit = job_nxt.pol.hit & live;
    job_nxt.tor.hit = job_nxt.tor.hit & live;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (take) begin
      front_v_r <= 1'b1;
    end else if (job_taken) begin
      front_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

  assign ready     = !front_v_r || job_taken;
  assign job_valid = front_v_r;
  assign job       = job_r;

endmodule

[design/ppcd_queue.sv]
// short queue of classified jobs between front end and divider
module ppcd_queue import ppcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        pop_job,
  output queue_stat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job    = slot_r[rd_ptr_r];
  assign stat.full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;

endmodule

[design/ppcd_back.sv]
// back end: pipelined fraction divider for both angles and the result register
module ppcd_back import ppcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      out_valid,
  output out_item_t out_item
);

  lane_t           pol_r [DIV_STEPS+1];
  lane_t           tor_r [DIV_STEPS+1];
  logic [DIV_STEPS:0] vld_r;
  logic            out_valid_r;
  out_item_t       out_item_r;
  out_item_t       out_item_nxt;

  // dividend is gap * 65535; quotient saturates once it needs a 17th bit
  function automatic lane_t lane_init(input axis_job_t a);
    lane_t       l;
    logic [32:0] prod;
    prod   = {a.gap, 16'd0} - {16'd0, a.gap};
    l.hit  = a.hit;
    l.idx  = a.idx;
    l.span = a.span;
    l.sat  = (a.span[31:16] == 16'd0) && (prod[31:16] >= a.span[15:0]);
    l.rem  = {16'd0, prod[31:16]};
    l.low  = prod[15:0];
    l.quo  = '0;
    return l;
  endfunction

  function automatic logic [15:0] lane_frac(input lane_t l);
    logic [15:0] f;
    if (!l.hit) begin
      f = '0;
    end else if (l.sat) begin
      f = FRAC_FULL;
    end else begin
      f = l.quo;
    end
    return f;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[DIV_STEPS-1:0], job_valid};
      out_valid_r <= vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    pol_r[0] <= lane_init(job.pol);
    tor_r[0] <= lane_init(job.tor);
    for (int i = 0; i < DIV_STEPS; i++) begin
      pol_r[i+1] <= div_step(pol_r[i]);
      tor_r[i+1] <= div_step(tor_r[i]);
    end
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    out_item_nxt.poloidal_hit      = pol_r[DIV_STEPS].hit;
    out_item_nxt.poloidal_index    = pol_r[DIV_STEPS].hit ? pol_r[DIV_STEPS].idx : 2'd0;
    out_item_nxt.poloidal_fraction = lane_frac(pol_r[DIV_STEPS]);
    out_item_nxt.toroidal_hit      = tor_r[DIV_STEPS].hit;
    out_item_nxt.toroidal_index    = tor_r[DIV_STEPS].hit ? tor_r[DIV_STEPS].idx : 2'd0;
    out_item_nxt.toroidal_fraction = lane_frac(tor_r[DIV_STEPS]);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/poincare_plane_crossing_detector_core.sv]
// top level: configuration registers, front end, job queue and divider back end
// throughput: one marker step per clock; busy only rises if the job queue fills
// each accepted step passes the front, queue and divider entry registers, then the
//   16-stage restoring divider and the output registers
// each result is shown for one cycle with out_valid; the receiver cannot stall
// reset (synchronous, rst_n low) clears all configuration to zero and empties the pipe
module poincare_plane_crossing_detector_core import ppcd_pkg::*; #(
  parameter int MAX_PLANES = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]  pol_count_r;
  logic [1:0]  tor_count_r;
  logic [15:0] pol_angle_r [MAX_PLANES];
  logic [15:0] tor_angle_r [MAX_PLANES];

  logic        cfg_wr;
  logic        take;
  logic        front_ready;
  logic        job_valid;
  job_t        front_job;
  logic        push;
  logic        pop;
  job_t        queue_job;
  queue_stat_t qstat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_count_r <= '0;
      tor_count_r <= '0;
      for (int k = 0; k < MAX_PLANES; k++) begin
        pol_angle_r[k] <= '0;
        tor_angle_r[k] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_index == CFG_POL_COUNT) begin
        pol_count_r <= cfg_data[1:0];
      end
      if (cfg_index == CFG_TOR_COUNT) begin
        tor_count_r <= cfg_data[1:0];
      end
      // angle writes for planes past the built count are dropped
      for (int k = 0; k < MAX_PLANES; k++) begin
        if (cfg_index == CFG_POL_ANGLE_BASE + CFG_IDX_W'(k)) begin
          pol_angle_r[k] <= cfg_data;
        end
        if (cfg_index == CFG_TOR_ANGLE_BASE + CFG_IDX_W'(k)) begin
          tor_angle_r[k] <= cfg_data;
        end
      end
    end
  end

  assign busy = !front_ready;
  assign take = start && !busy;
  assign push = job_valid && !qstat.full;
  assign pop  = !qstat.empty;

  ppcd_front #(
    .MAX_PLANES(MAX_PLANES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_item),
    .pol_count (pol_count_r),
    .tor_count (tor_count_r),
    .pol_angle (pol_angle_r),
    .tor_angle (tor_angle_r),
    .ready     (front_ready),
    .job_valid (job_valid),
    .job       (front_job),
    .job_taken (push)
  );

  ppcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .pop_job  (queue_job),
    .stat     (qstat)
  );

  ppcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop),
    .job       (queue_job),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[design/ppcd_checker.sv]
// port-level checks on the crossing detector, bound to the top level
module ppcd_checker import ppcd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_item,
  input logic                  out_valid,
  input out_item_t             out_item,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic accept;
  logic dead_step;

  assign accept    = start && !busy;
  assign dead_step = (in_item.marker_id == DUMMY_ID) ||
                     (in_item.start_time == in_item.end_time);

  // a result without a crossing carries zero index and fraction
  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_item.poloidal_hit || (out_item.poloidal_index == 2'd0 &&
                                 out_item.poloidal_fraction == 16'd0)) &&
      (out_item.toroidal_hit || (out_item.toroidal_index == 2'd0 &&
                                 out_item.toroidal_fraction == 16'd0)))
    else $error("miss result with nonzero index or fraction");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.poloidal_index != 2'd3) && (out_item.toroidal_index != 2'd3))
    else $error("plane index out of range");

  // dummy marker or rejected step yields a no-hit result at fixed latency
  a_dead_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dead_step) |-> ##LATENCY
      (out_valid && !out_item.poloidal_hit && !out_item.toroidal_hit))
    else $error("dead step did not give an empty result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transaction");

  // register writes are always taken and carry known index and data
  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
    else $error("configuration transaction refused or unknown");

endmodule

bind poincare_plane_crossing_detector_core ppcd_checker u_ppcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

[tb/poincare_plane_crossing_detector_core_tb.sv]
// self-checking testbench for the poincare plane crossing detector core
`timescale 1ns / 1ps

module poincare_plane_crossing_detector_core_tb;
  import ppcd_pkg::*;

  localparam int PLANES        = 3;
  localparam int SEG_ITEMS     = 250;
  localparam int SEGMENTS      = 7;
  localparam int DRAIN_CYCLES  = LATENCY + 4;
  localparam logic [63:0] TURN_BIAS = 64'h1_0000_0000;
  localparam longint FRAC_SCALE = 65535;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_TOR_ANGLE_BASE + 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int settings_used = 0;

  poincare_plane_crossing_detector_core #(
    .MAX_PLANES(PLANES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  class crossing_scoreboard;
    logic [1:0]       pol_count;
    logic [1:0]       tor_count;
    logic [2:0][15:0] pol_angle;
    logic [2:0][15:0] tor_angle;
    out_item_t        crossing_q[$];
    int               mismatches;
    int               checked;
    int               steps;
    int               pol_hits;
    int               tor_hits;

    function new();
      pol_count  = '0;
      tor_count  = '0;
      pol_angle  = '0;
      tor_angle  = '0;
      mismatches = 0;
      checked    = 0;
      steps      = 0;
      pol_hits   = 0;
      tor_hits   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_POL_COUNT) begin
        pol_count = data[1:0];
      end else if (idx == CFG_TOR_COUNT) begin
        tor_count = data[1:0];
      end else if (idx >= CFG_POL_ANGLE_BASE && idx < CFG_TOR_ANGLE_BASE) begin
        pol_angle[idx - CFG_POL_ANGLE_BASE] = data;
      end else if (idx >= CFG_TOR_ANGLE_BASE && idx < CFG_FIRST_UNUSED) begin
        tor_angle[idx - CFG_TOR_ANGLE_BASE] = data;
      end
      // indexes past the register list are dropped
    endfunction

    // first plane whose turn boundary lies between the two angles
    function void scan_planes(input logic [1:0] count, input logic [2:0][15:0] ang,
                              input longint st, input longint en, output logic hit,
                              output logic [1:0] idx, output logic [15:0] frac);
      longint      s;
      longint      e;
      longint      gap;
      longint      span;
      longint      q;
      logic [63:0] bs;
      logic [63:0] be;
      int          n;
      hit  = 1'b0;
      idx  = '0;
      frac = '0;
      n    = (count > PLANES) ? PLANES : count;
      for (int k = 0; k < n; k++) begin
        s  = st + longint'(ang[k]);
        e  = en + longint'(ang[k]);
        bs = 64'(s) + TURN_BIAS;
        be = 64'(e) + TURN_BIAS;
        if (bs[63:16] != be[63:16]) begin
          if (e > s) begin
            gap  = 65536 - longint'(bs[15:0]);
            span = e - s;
          end else begin
            // moving down: start on a boundary gives zero
            gap  = longint'(bs[15:0]);
            span = s - e;
          end
          q = (gap * FRAC_SCALE) / span;
          if (q > FRAC_SCALE) q = FRAC_SCALE;
          hit  = 1'b1;
          idx  = k[1:0];
          frac = q[15:0];
          return;
        end
      end
    endfunction

    function void note_step(in_item_t it);
      out_item_t r;
      r = '0;
      steps++;
      if (it.marker_id != DUMMY_ID && it.start_time != it.end_time) begin
        scan_planes(pol_count, pol_angle, longint'($signed(it.start_toroidal)),
                    longint'($signed(it.end_toroidal)), r.poloidal_hit,
                    r.poloidal_index, r.poloidal_fraction);
        scan_planes(tor_count, tor_angle, longint'($signed(it.start_poloidal)),
                    longint'($signed(it.end_poloidal)), r.toroidal_hit,
                    r.toroidal_index, r.toroidal_fraction);
      end
      crossing_q.push_back(r);
    endfunction

    function void note_fail(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (crossing_q.size() == 0) begin
        note_fail($sformatf("result with no step pending: pol %0b/%0d/%0d tor %0b/%0d/%0d",
                            got.poloidal_hit, got.poloidal_index, got.poloidal_fraction,
                            got.toroidal_hit, got.toroidal_index, got.toroidal_fraction));
        return;
      end
      exp = crossing_q.pop_front();
      checked++;
      if (got.poloidal_hit !== exp.poloidal_hit ||
          got.poloidal_index !== exp.poloidal_index ||
          got.poloidal_fraction !== exp.poloidal_fraction ||
          got.toroidal_hit !== exp.toroidal_hit ||
          got.toroidal_index !== exp.toroidal_index ||
          got.toroidal_fraction !== exp.toroidal_fraction) begin
        note_fail($sformatf(
          "exp pol %0b/%0d/%0d tor %0b/%0d/%0d, got pol %0b/%0d/%0d tor %0b/%0d/%0d",
          exp.poloidal_hit, exp.poloidal_index, exp.poloidal_fraction,
          exp.toroidal_hit, exp.toroidal_index, exp.toroidal_fraction,
          got.poloidal_hit, got.poloidal_index, got.poloidal_fraction,
          got.toroidal_hit, got.toroidal_index, got.toroidal_fraction));
      end
      if (exp.poloidal_hit) pol_hits++;
      if (exp.toroidal_hit) tor_hits++;
    endfunction

    function void flush_check();
      if (crossing_q.size() != 0)
        note_fail($sformatf("%0d results never arrived", crossing_q.size()));
    endfunction
  endclass

  crossing_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("poincare_plane_crossing_detector_core_tb: FAIL");
    $finish;
  end

  // sample before the edge updates take effect
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_step(in_item);
      if (out_valid) sb.check_result(out_item);
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [1:0] pcnt, input logic [1:0] tcnt,
                              input logic [2:0][15:0] pang, input logic [2:0][15:0] tang);
    logic [31:0] junk;
    junk = $urandom;
    // upper data bits of the count writes must be masked off
    cfg_write(CFG_POL_COUNT, {junk[13:0], pcnt}, 1'b0);
    cfg_write(CFG_TOR_COUNT, {junk[29:16], tcnt}, 1'b0);
    cfg_write(settings_used[0] ? CFG_LAST_UNUSED : CFG_FIRST_UNUSED, junk[31:16], 1'b0);
    for (int k = 0; k < 3; k++) cfg_write(CFG_IDX_W'(CFG_POL_ANGLE_BASE + k), pang[k], 1'b0);
    for (int k = 0; k < 3; k++)
      cfg_write(CFG_IDX_W'(CFG_TOR_ANGLE_BASE + k), tang[k], k == 2);
    settings_used++;
  endtask

  task automatic send_item(input in_item_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let every pending transaction come back
  task automatic drain_pipe();
    start <= 1'b0;
    while (sb.crossing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_step(logic [31:0] id, logic [31:0] t0, logic [31:0] t1,
                                         logic [31:0] st, logic [31:0] et,
                                         logic [31:0] sp, logic [31:0] ep);
    in_item_t it;
    it.marker_id      = id;
    it.start_time     = t0;
    it.end_time       = t1;
    it.start_toroidal = st;
    it.end_toroidal   = et;
    it.start_poloidal = sp;
    it.end_poloidal   = ep;
    return it;
  endfunction

  // mostly short steps near plane boundaries, some wild jumps and standstills
  function automatic void rand_axis(output logic [31:0] a0, output logic [31:0] a1);
    int          mode;
    int          d;
    logic [31:0] r;
    mode = $urandom_range(99);
    r    = $urandom;
    a0   = $urandom;
    if (mode < 55) begin
      d  = int'($urandom_range(393216)) - 196608;
      a1 = a0 + d;
    end else if (mode < 75) begin
      a0 = {r[31:16], r[0] ? 16'hFFFF : 16'h0000};
      d  = int'($urandom_range(600)) - 300;
      a1 = a0 + d;
    end else if (mode < 90) begin
      a1 = $urandom;
    end else begin
      a1 = a0 + $urandom_range(2) - 1;
    end
  endfunction

  function automatic in_item_t random_step();
    in_item_t    it;
    int          pick;
    logic [31:0] a0;
    logic [31:0] a1;
    pick = $urandom_range(99);
    if (pick < 8)       it.marker_id = DUMMY_ID;
    else if (pick < 12) it.marker_id = 32'h7FFF_FFFF;
    else if (pick < 18) it.marker_id = $urandom;
    else                it.marker_id = $urandom & 32'h7FFF_FFFF;
    it.start_time = $urandom;
    pick = $urandom_range(99);
    if (pick < 10)      it.end_time = it.start_time;
    else if (pick < 20) it.end_time = it.start_time + 1;
    else                it.end_time = $urandom;
    rand_axis(a0, a1);
    it.start_toroidal = a0;
    it.end_toroidal   = a1;
    rand_axis(a0, a1);
    it.start_poloidal = a0;
    it.end_poloidal   = a1;
    return it;
  endfunction

  initial begin
    logic [2:0][15:0] pang;
    logic [2:0][15:0] tang;
    logic [1:0]       pcnt;
    logic [1:0]       tcnt;
    int               idle_pct;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: no planes in use
    send_item(make_step(32'd1, 32'd0, 32'd1, 32'hFFFF_FFF0, 32'h0000_0010,
                        32'hFFFF_0000, 32'h0001_0000), 0);
    send_item(make_step(32'd2, 32'd5, 32'd9, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000), 0);
    drain_pipe();

    load_setting(2'd3, 2'd3, {16'hFFFF, 16'h4000, 16'h0000},
                 {16'hFFFF, 16'h0000, 16'h8000});
    // plain crossings, both moving up
    send_item(make_step(32'd0, 32'd0, 32'd1, 32'h0000_FFF6, 32'h0001_0010,
                        32'hFFFF_FFFB, 32'h0000_0005), 0);
    // dummy marker and rejected step see nothing
    send_item(make_step(DUMMY_ID, 32'd0, 32'd1, 32'h0000_FFF6, 32'h0001_0010,
                        32'hFFFF_FFFB, 32'h0000_0005), 0);
    send_item(make_step(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFF6,
                        32'h0001_0010, 32'hFFFF_FFFB, 32'h0000_0005), 0);
    // full-range jumps at the angle extremes
    send_item(make_step(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 0);
    // start right on a boundary while moving down
    send_item(make_step(32'd4, 32'd1, 32'd2, 32'h0000_0000, 32'hFFFF_FF9C,
                        32'h0000_8000, 32'h0000_7000), 0);
    // landing exactly on a boundary gives a full fraction
    send_item(make_step(32'd5, 32'd1, 32'd2, 32'hFFFF_FFF6, 32'h0000_0000,
                        32'hFFFF_7FF6, 32'hFFFF_8000), 0);
    // second and third planes first
    send_item(make_step(32'd6, 32'd1, 32'd2, 32'h0000_B000, 32'h0000_D000,
                        32'h0000_0000, 32'h0000_0005), 0);
    send_item(make_step(32'd7, 32'd1, 32'd2, 32'h0000_0000, 32'h0000_0005,
                        32'h0000_1000, 32'h0000_0FF0), 0);
    // no motion at all
    send_item(make_step(32'd8, 32'd1, 32'd2, 32'h0000_0005, 32'h0000_0005,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    send_item(make_step(32'hFFFF_FFFE, 32'd1, 32'd2, 32'h8000_0000, 32'h8000_0123,
                        32'h7FFF_FF00, 32'h7FFF_FFFF), 0);
    send_item(make_step(32'h8000_0000, 32'd2, 32'd1, 32'h7FFF_FF00, 32'h7FFF_FFFF,
                        32'h8000_0100, 32'h8000_0000), 0);
    drain_pipe();

    // fewer planes: the later ones must be skipped
    load_setting(2'd1, 2'd2, {16'hFFFF, 16'h4000, 16'h0000},
                 {16'hFFFF, 16'h0000, 16'h8000});
    send_item(make_step(32'd9, 32'd1, 32'd2, 32'h0000_B000, 32'h0000_D000,
                        32'h0000_0000, 32'h0000_0005), 0);
    send_item(make_step(32'd10, 32'd1, 32'd2, 32'h0000_0000, 32'h0000_0005,
                        32'h0000_8010, 32'h0000_7FF0), 0);
    send_item(make_step(32'd11, 32'd1, 32'd2, 32'h0000_FFF6, 32'h0001_0010,
                        32'hFFFF_FFFB, 32'h0000_0005), 0);
    drain_pipe();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pcnt = 2'($urandom_range(3));
      tcnt = 2'($urandom_range(3));
      for (int k = 0; k < 3; k++) begin
        pang[k] = 16'($urandom_range(65535));
        tang[k] = 16'($urandom_range(65535));
      end
      case (seg)
        1: begin
          pcnt = 2'd3;
          tcnt = 2'd3;
          pang = '1;
          tang = '1;
        end
        2: begin
          pcnt = 2'd0;
          tcnt = 2'd0;
        end
        4: begin
          pcnt = 2'd3;
          tcnt = 2'd3;
          pang = '0;
          tang = '0;
        end
        default: ;
      endcase
      idle_pct = (seg < 3) ? 15 : (seg < 5) ? 84 : 0;
      load_setting(pcnt, tcnt, pang, tang);
      for (int i = 0; i < SEG_ITEMS; i++) send_item(random_step(), idle_pct);
      drain_pipe();
    end

    sb.flush_check();
    $display("checked %0d results from %0d marker steps over %0d register settings",
             sb.checked, sb.steps, settings_used);
    $display("saw %0d poloidal and %0d toroidal crossings, %0d mismatches",
             sb.pol_hits, sb.tor_hits, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("poincare_plane_crossing_detector_core_tb: PASS");
    end else begin
      $display("poincare_plane_crossing_detector_core_tb: FAIL");
    end
    $finish;
  end

endmodule
